// ===== rtl/core/vlw_pkg.sv =====
// Package for the video memory logic-op write engine.
// Holds the sequencer state type and the operation, mode and register codes.
// No dependencies.
`timescale 1ns / 1ps

package vlw_pkg;

	localparam int CURSOR_W   = 18;
	localparam int STEP_W     = 14;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ACCESS,
		ST_MODIFY
	} state_t;

	localparam logic [1:0] FUNC_DMA_WRITE   = 2'd0;
	localparam logic [1:0] FUNC_DMA_READ    = 2'd1;
	localparam logic [1:0] FUNC_FILL        = 2'd2;
	localparam logic [1:0] FUNC_LOAD_CURSOR = 2'd3;

	localparam logic [1:0] WM_REPLACE = 2'd0;
	localparam logic [1:0] WM_XOR     = 2'd1;
	localparam logic [1:0] WM_CLEAR   = 2'd2;
	localparam logic [1:0] WM_SET     = 2'd3;

	localparam logic [1:0] TT_ALTERNATE = 2'd0;
	localparam logic [1:0] TT_LOW_ONLY  = 2'd1;
	localparam logic [1:0] TT_HIGH_ONLY = 2'd2;
	localparam logic [1:0] TT_NONE      = 2'd3;

	localparam logic [CFG_IDX_W-1:0] REG_WRITE_MODE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TRANSFER_TYPE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MASK_LOW        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MASK_HIGH       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ADDRESS_STEP    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DATA_WIDTH_MASK = 3'd5;

	localparam logic [7:0] BYTE_ALL_ONES = 8'hff;

endpackage

// ===== rtl/core/vram_logic_op_write_engine.sv =====
// Top level of the video memory logic-op write engine: sequencer, cursor and registers.
// Depends on vlw_pkg, vlw_ram and vlw_alu.
//
// Channel   | Signals                                                 | Handshake
// request   | func, data_low, data_high, repeat_count, new_cursor     | start && !busy
// result    | read_data, cursor_now                                   | done, one cycle
// config    | cfg_index, cfg_data                                     | cfg_write
//
// Every byte access uses the single RAM port: a read in ST_ACCESS, then a write in
// ST_MODIFY for a write request in range. A cursor load or TT_NONE makes no access;
// the result strobe follows in the next cycle, when a new request can already be taken.
// Reset sets the registers to their defaults and clears the cursor; memory stays undefined.
// The receiver cannot stall; done is high for exactly one cycle per request.
`timescale 1ns / 1ps

module vram_logic_op_write_engine
	import vlw_pkg::*;
#(
	parameter int MEM_BYTES = 65536
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [1:0]            func,
	input  logic [7:0]            data_low,
	input  logic [7:0]            data_high,
	input  logic [13:0]           repeat_count,
	input  logic [CURSOR_W-1:0]   new_cursor,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output logic                  done,
	output logic [7:0]            read_data,
	output logic [CURSOR_W-1:0]   cursor_now
);

	localparam int ADDR_W = $clog2(MEM_BYTES);
	localparam logic [CURSOR_W+1:0] MEM_LIMIT = (CURSOR_W + 2)'(MEM_BYTES);

	logic [1:0]               write_mode_q;
	logic [1:0]               transfer_type_q;
	logic [7:0]               mask_low_q;
	logic [7:0]               mask_high_q;
	logic signed [STEP_W-1:0] address_step_q;
	logic [15:0]              data_width_mask_q;

	state_t                state_q, state_d;
	logic [CURSOR_W-1:0]   cursor_q;
	logic                  high_next_q;
	logic                  hi_q;
	logic                  fill_q;
	logic                  is_write_q;
	logic                  dma_step_q;
	logic [13:0]           cnt_q;
	logic [7:0]            dl_q;
	logic [7:0]            dh_q;
	logic                  done_q;
	logic [7:0]            read_data_q;

	logic                  accept;
	logic                  word_end;
	logic                  last_byte;
	logic                  step_now;
	logic                  ram_re;
	logic                  ram_we;
	logic [CURSOR_W:0]     byte_addr;
	logic                  in_range;
	logic [7:0]            ram_rdata;
	logic [7:0]            wdata;
	logic [7:0]            width_mask;
	logic [7:0]            read_value;
	logic [7:0]            write_value;
	logic [CURSOR_W-1:0]   cursor_stepped;

	assign accept    = start && (state_q == ST_IDLE);
	assign busy      = (state_q != ST_IDLE);
	assign byte_addr = {cursor_q, hi_q};
	assign in_range  = {1'b0, byte_addr} < MEM_LIMIT;
	assign wdata      = hi_q ? (dh_q & mask_high_q) : (dl_q & mask_low_q);
	assign width_mask = hi_q ? data_width_mask_q[15:8] : data_width_mask_q[7:0];
	assign cursor_stepped = cursor_q
		+ {{(CURSOR_W - STEP_W){address_step_q[STEP_W-1]}}, address_step_q};

	assign word_end  = hi_q || (transfer_type_q == TT_LOW_ONLY);
	assign last_byte = !fill_q || (word_end && (cnt_q == '0));
	assign step_now  = fill_q ? word_end : dma_step_q;

	assign done       = done_q;
	assign read_data  = read_data_q;
	assign cursor_now = cursor_q;

	vlw_ram #(
		.WIDTH(8),
		.DEPTH(MEM_BYTES)
	) u_ram (
		.clk  (clk),
		.re   (ram_re),
		.we   (ram_we),
		.addr (byte_addr[ADDR_W-1:0]),
		.wdata(write_value),
		.rdata(ram_rdata)
	);

	vlw_alu u_alu (
		.write_mode (write_mode_q),
		.mem_byte   (ram_rdata),
		.width_mask (width_mask),
		.in_range   (in_range),
		.wdata      (wdata),
		.read_value (read_value),
		.write_value(write_value)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ram_re  = 1'b0;
		ram_we  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && func != FUNC_LOAD_CURSOR && transfer_type_q != TT_NONE) begin
					state_d = ST_ACCESS;
				end
			end
			ST_ACCESS: begin
				ram_re  = 1'b1;
				state_d = ST_MODIFY;
			end
			ST_MODIFY: begin
				ram_we  = is_write_q && in_range;
				state_d = last_byte ? ST_IDLE : ST_ACCESS;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_mode_q      <= WM_REPLACE;
			transfer_type_q   <= TT_ALTERNATE;
			mask_low_q        <= BYTE_ALL_ONES;
			mask_high_q       <= BYTE_ALL_ONES;
			address_step_q    <= STEP_W'(1);
			data_width_mask_q <= 16'hffff;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_WRITE_MODE:      write_mode_q      <= cfg_data[1:0];
				REG_TRANSFER_TYPE:   transfer_type_q   <= cfg_data[1:0];
				REG_MASK_LOW:        mask_low_q        <= cfg_data[7:0];
				REG_MASK_HIGH:       mask_high_q       <= cfg_data[7:0];
				REG_ADDRESS_STEP:    address_step_q    <= cfg_data[STEP_W-1:0];
				REG_DATA_WIDTH_MASK: data_width_mask_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q    <= '0;
			high_next_q <= 1'b0;
			done_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (accept) begin
				if (func == FUNC_LOAD_CURSOR) begin
					cursor_q <= new_cursor;
					done_q   <= 1'b1;
				end else if (transfer_type_q == TT_NONE) begin
					done_q <= 1'b1;
				end else if (func != FUNC_FILL && transfer_type_q == TT_ALTERNATE) begin
					high_next_q <= !high_next_q;
				end
			end else if (state_q == ST_MODIFY) begin
				if (step_now) begin
					cursor_q <= cursor_stepped;
				end
				if (last_byte) begin
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			read_data_q <= BYTE_ALL_ONES;
			dl_q        <= data_low;
			cnt_q       <= repeat_count;
			fill_q      <= (func == FUNC_FILL);
			is_write_q  <= (func != FUNC_DMA_READ);
			if (func == FUNC_FILL) begin
				dh_q       <= data_high;
				hi_q       <= (transfer_type_q == TT_HIGH_ONLY);
				dma_step_q <= 1'b1;
			end else begin
				dh_q <= data_low;
				if (transfer_type_q == TT_ALTERNATE) begin
					hi_q       <= high_next_q;
					dma_step_q <= high_next_q;
				end else begin
					hi_q       <= (transfer_type_q == TT_HIGH_ONLY);
					dma_step_q <= 1'b1;
				end
			end
		end else if (state_q == ST_MODIFY) begin
			if (!is_write_q) begin
				read_data_q <= read_value;
			end
			if (fill_q) begin
				if (!word_end) begin
					hi_q <= 1'b1;
				end else begin
					hi_q  <= (transfer_type_q == TT_HIGH_ONLY);
					cnt_q <= cnt_q - 14'd1;
				end
			end
		end
	end

	// The result strobe is raised only while the sequencer is idle.
	assert property (@(posedge clk) disable iff (!arst_n) done_q |-> state_q == ST_IDLE)
		else $error("Result strobe while the sequencer is busy.");

	// A read cycle is always followed by its modify cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ACCESS |=> state_q == ST_MODIFY)
		else $error("Read cycle not followed by a modify cycle.");

	// Memory is written only in the modify cycle and never by a DMA read.
	assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == ST_MODIFY && is_write_q))
		else $error("Memory write outside a write request's modify cycle.");

	// A cursor load completes in the next cycle with the new cursor.
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && func == FUNC_LOAD_CURSOR) |=> (done_q && cursor_q == $past(new_cursor)))
		else $error("Cursor load did not complete with the requested cursor.");

endmodule

// ===== rtl/core/vlw_ram.sv =====
// Generic single-port RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module vlw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     re,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

// ===== rtl/core/vlw_alu.sv =====
// Byte combine unit shared by every memory access of the engine.
// Applies the data-width mask to the memory byte and forms the write value.
// Depends on vlw_pkg.
`timescale 1ns / 1ps

module vlw_alu
	import vlw_pkg::*;
(
	input  logic [1:0] write_mode,
	input  logic [7:0] mem_byte,
	input  logic [7:0] width_mask,
	input  logic       in_range,
	input  logic [7:0] wdata,
	output logic [7:0] read_value,
	output logic [7:0] write_value
);

	always_comb begin
		if (in_range) begin
			read_value = (mem_byte & width_mask) | ~width_mask;
		end else begin
			read_value = BYTE_ALL_ONES;
		end
		case (write_mode)
			WM_REPLACE: write_value = wdata;
			WM_XOR:     write_value = read_value ^ wdata;
			WM_CLEAR:   write_value = read_value & ~wdata;
			default:    write_value = read_value | wdata;
		endcase
	end

endmodule
